// ----- hdl/bsp_point_contents_walk_assert.svh -----
// assertion macros used by the checker of the point contents walk
`ifndef BSP_POINT_CONTENTS_WALK_ASSERT_SVH
`define BSP_POINT_CONTENTS_WALK_ASSERT_SVH

// same-cycle implication
`define BPCW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication
`define BPCW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ----- hdl/bpcw_pkg.sv -----
`timescale 1ns / 1ps
package bpcw_pkg;

	localparam logic [1:0] OP_LOAD_NODE  = 2'd0;
	localparam logic [1:0] OP_LOAD_PLANE = 2'd1;
	localparam logic [1:0] OP_QUERY      = 2'd2;

	localparam logic [1:0] CL_NOP   = 2'd0;
	localparam logic [1:0] CL_NODE  = 2'd1;
	localparam logic [1:0] CL_PLANE = 2'd2;
	localparam logic [1:0] CL_QUERY = 2'd3;

	localparam logic REG_FIRST_NODE = 1'b0;
	localparam logic REG_LAST_NODE  = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_NODE = 2'd1;
	localparam logic [1:0] STATUS_LOOP     = 2'd2;

	localparam logic [2:0] AXIAL_KINDS = 3'd3;
	localparam logic [2:0] KIND_X      = 3'd0;
	localparam logic [2:0] KIND_Y      = 3'd1;

	localparam int ACC_W = 66;

	typedef struct packed {
		logic [1:0]          cls;
		logic [9:0]          index;
		logic [9:0]          plane_num;
		logic signed [10:0]  child_front;
		logic signed [10:0]  child_back;
		logic [2:0]          kind;
		logic signed [31:0]  vx;
		logic signed [31:0]  vy;
		logic signed [31:0]  vz;
		logic signed [31:0]  offs;
	} bpcw_item_t;

	typedef struct packed {
		logic [9:0]          plane_idx;
		logic signed [10:0]  front;
		logic signed [10:0]  back;
	} bpcw_node_t;

	typedef struct packed {
		logic [2:0]          kind;
		logic signed [31:0]  nx;
		logic signed [31:0]  ny;
		logic signed [31:0]  nz;
		logic signed [31:0]  offs;
	} bpcw_plane_t;

endpackage

// ----- hdl/bpcw_ram.sv -----
`timescale 1ns / 1ps
module bpcw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- hdl/bpcw_front.sv -----
`timescale 1ns / 1ps
module bpcw_front #(
	parameter int NODE_COUNT  = 1024,
	parameter int PLANE_COUNT = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              op,
	input  logic [9:0]              index,
	input  logic [9:0]              plane_num,
	input  logic signed [10:0]      child_front,
	input  logic signed [10:0]      child_back,
	input  logic [2:0]              plane_type,
	input  logic signed [31:0]      vec_x,
	input  logic signed [31:0]      vec_y,
	input  logic signed [31:0]      vec_z,
	input  logic signed [31:0]      plane_offset,
	output logic                    q_push,
	output bpcw_pkg::bpcw_item_t    q_item,
	input  logic                    q_full
);
	import bpcw_pkg::*;

	// plane index reduction: quotient by reciprocal, then one correction
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = 21;
	localparam int PROD_W      = 10 + RECIP_W;
	localparam int QC_W        = 27;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / PLANE_COUNT);
	localparam logic [QC_W-1:0]    PC_W  = QC_W'(PLANE_COUNT);

	bpcw_item_t        item_in;
	bpcw_item_t        item_s1;
	bpcw_item_t        item_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic [PROD_W-1:0] prod_s1;
	logic [QC_W-1:0]   qc_s2;
	logic [QC_W-1:0]   rem_raw;
	logic [QC_W-1:0]   rem;
	logic              adv_s1;
	logic              adv_s2;
	logic              node_ok;
	logic              plane_ok;

	assign node_ok  = 32'(index) < 32'(NODE_COUNT);
	assign plane_ok = 32'(index) < 32'(PLANE_COUNT);

	always_comb begin
		item_in.index       = index;
		item_in.plane_num   = plane_num;
		item_in.child_front = child_front;
		item_in.child_back  = child_back;
		item_in.kind        = plane_type;
		item_in.vx          = vec_x;
		item_in.vy          = vec_y;
		item_in.vz          = vec_z;
		item_in.offs        = plane_offset;
		unique case (op)
			OP_LOAD_NODE:  item_in.cls = node_ok ? CL_NODE : CL_NOP;
			OP_LOAD_PLANE: item_in.cls = plane_ok ? CL_PLANE : CL_NOP;
			OP_QUERY:      item_in.cls = CL_QUERY;
			default:       item_in.cls = CL_NOP;
		endcase
	end

	assign adv_s2   = valid_s2 && !q_full;
	assign adv_s1   = valid_s1 && (!valid_s2 || adv_s2);
	assign in_ready = !valid_s1 || adv_s1;
	assign q_push   = adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
			prod_s1 <= PROD_W'(item_in.plane_num) * PROD_W'(RECIP);
		end
		if (adv_s1) begin
			item_s2 <= item_s1;
			qc_s2   <= QC_W'(prod_s1[RECIP_SHIFT +: 10]) * PC_W;
		end
	end

	assign rem_raw = QC_W'(item_s2.plane_num) - qc_s2;
	assign rem     = (rem_raw >= PC_W) ? rem_raw - PC_W : rem_raw;

	always_comb begin
		q_item           = item_s2;
		q_item.plane_num = rem[9:0];
	end
endmodule

// ----- hdl/bpcw_queue.sv -----
`timescale 1ns / 1ps
module bpcw_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bpcw_pkg::bpcw_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output bpcw_pkg::bpcw_item_t pop_item,
	output logic                 empty
);
	import bpcw_pkg::*;

	bpcw_item_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end
endmodule

// ----- hdl/bpcw_walk.sv -----
`timescale 1ns / 1ps
module bpcw_walk #(
	parameter int NODE_COUNT  = 1024,
	parameter int PLANE_COUNT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	output logic                 q_pop,
	input  bpcw_pkg::bpcw_item_t q_item,
	input  logic [9:0]           first_node,
	input  logic [9:0]           last_node,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [4:0]    contents,
	output logic [1:0]           status
);
	import bpcw_pkg::*;

	localparam int NODE_AW  = $clog2(NODE_COUNT);
	localparam int PLANE_AW = $clog2(PLANE_COUNT);
	localparam int STEP_W   = $clog2(NODE_COUNT + 1);
	localparam int NODE_W   = $bits(bpcw_node_t);
	localparam int PLANE_W  = $bits(bpcw_plane_t);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CHECK = 4'd1;
	localparam logic [3:0] ST_NODE  = 4'd2;
	localparam logic [3:0] ST_PLANE = 4'd3;
	localparam logic [3:0] ST_MY    = 4'd4;
	localparam logic [3:0] ST_MZ    = 4'd5;
	localparam logic [3:0] ST_MS    = 4'd6;
	localparam logic [3:0] ST_STEP  = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0]               state_q;
	logic [9:0]               num_q;
	logic [STEP_W-1:0]        steps_q;
	logic signed [31:0]       px_q;
	logic signed [31:0]       py_q;
	logic signed [31:0]       pz_q;
	logic                     behind_q;
	logic signed [63:0]       prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [4:0]        res_contents_q;
	logic [1:0]               res_status_q;
	logic                     out_valid_q;
	logic signed [4:0]        contents_q;
	logic [1:0]               status_q;

	bpcw_node_t               node_rd;
	bpcw_plane_t              plane_rd;
	bpcw_node_t               node_wr;
	bpcw_plane_t              plane_wr;
	logic [NODE_W-1:0]        node_rdata;
	logic [PLANE_W-1:0]       plane_rdata;
	logic                     node_we;
	logic                     plane_we;
	logic [31:0]              idx32;
	logic [31:0]              num32;
	logic [31:0]              pidx32;
	logic                     bad_node;
	logic                     out_free;
	logic signed [31:0]       axis_val;
	logic signed [32:0]       axis_diff;
	logic signed [ACC_W-1:0]  dist_ext;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  acc_sum;
	logic signed [10:0]       child;
	logic signed [31:0]       mul_a;
	logic signed [31:0]       mul_b;

	assign idx32  = 32'(q_item.index);
	assign num32  = 32'(num_q);
	assign pidx32 = 32'(node_rd.plane_idx);

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign node_we  = q_pop && (q_item.cls == CL_NODE);
	assign plane_we = q_pop && (q_item.cls == CL_PLANE);

	always_comb begin
		node_wr.plane_idx = q_item.plane_num;
		node_wr.front     = q_item.child_front;
		node_wr.back      = q_item.child_back;
		plane_wr.kind     = q_item.kind;
		plane_wr.nx       = q_item.vx;
		plane_wr.ny       = q_item.vy;
		plane_wr.nz       = q_item.vz;
		plane_wr.offs     = q_item.offs;
	end

	bpcw_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (idx32[NODE_AW-1:0]),
		.wdata (node_wr),
		.raddr (num32[NODE_AW-1:0]),
		.rdata (node_rdata)
	);

	bpcw_ram #(.WIDTH(PLANE_W), .DEPTH(PLANE_COUNT)) u_plane_ram (
		.clk   (clk),
		.we    (plane_we),
		.waddr (idx32[PLANE_AW-1:0]),
		.wdata (plane_wr),
		.raddr (pidx32[PLANE_AW-1:0]),
		.rdata (plane_rdata)
	);

	assign node_rd  = node_rdata;
	assign plane_rd = plane_rdata;

	assign bad_node = (num_q < first_node) || (num_q > last_node) ||
		(num32 >= 32'(NODE_COUNT));
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		case (plane_rd.kind)
			KIND_X:  axis_val = px_q;
			KIND_Y:  axis_val = py_q;
			default: axis_val = pz_q;
		endcase
	end

	// one shared multiplier, operands picked per axis
	always_comb begin
		case (state_q)
			ST_MY: begin
				mul_a = plane_rd.ny;
				mul_b = py_q;
			end
			ST_MZ: begin
				mul_a = plane_rd.nz;
				mul_b = pz_q;
			end
			default: begin
				mul_a = plane_rd.nx;
				mul_b = px_q;
			end
		endcase
	end

	// axial plane: sign of component minus distance
	assign axis_diff = {axis_val[31], axis_val} - {plane_rd.offs[31], plane_rd.offs};
	assign dist_ext  = {{(ACC_W - 48){plane_rd.offs[31]}}, plane_rd.offs, 16'b0};
	assign prod_ext  = {{(ACC_W - 64){prod_q[63]}}, prod_q};
	assign acc_sum   = acc_q + prod_ext;
	assign child     = behind_q ? node_rd.back : node_rd.front;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= (q_item.cls == CL_QUERY) ? ST_CHECK : ST_DONE;
					end
				end
				ST_CHECK: begin
					if (steps_q == STEP_W'(NODE_COUNT) || bad_node) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_NODE;
					end
				end
				ST_NODE:  state_q <= ST_PLANE;
				ST_PLANE: state_q <= (plane_rd.kind < AXIAL_KINDS) ? ST_STEP : ST_MY;
				ST_MY:    state_q <= ST_MZ;
				ST_MZ:    state_q <= ST_MS;
				ST_MS:    state_q <= ST_STEP;
				ST_STEP:  state_q <= child[10] ? ST_DONE : ST_CHECK;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				num_q          <= q_item.index;
				steps_q        <= '0;
				px_q           <= q_item.vx;
				py_q           <= q_item.vy;
				pz_q           <= q_item.vz;
				res_contents_q <= '0;
				res_status_q   <= STATUS_OK;
			end
			ST_CHECK: begin
				if (steps_q == STEP_W'(NODE_COUNT)) begin
					res_status_q <= STATUS_LOOP;
				end else if (bad_node) begin
					res_status_q <= STATUS_BAD_NODE;
				end
			end
			ST_PLANE: begin
				behind_q <= axis_diff[32];
				prod_q   <= mul_a * mul_b;
				acc_q    <= -dist_ext;
			end
			ST_MY: begin
				acc_q  <= acc_sum;
				prod_q <= mul_a * mul_b;
			end
			ST_MZ: begin
				acc_q  <= acc_sum;
				prod_q <= mul_a * mul_b;
			end
			ST_MS: begin
				behind_q <= acc_sum[ACC_W-1];
			end
			ST_STEP: begin
				steps_q <= steps_q + STEP_W'(1);
				num_q   <= child[9:0];
				if (child[10]) begin
					res_contents_q <= (child < -11'sd16) ? -5'sd16 : child[4:0];
				end
			end
			ST_DONE: begin
				if (out_free) begin
					contents_q <= res_contents_q;
					status_q   <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign contents  = contents_q;
	assign status    = status_q;
endmodule

// ----- hdl/bsp_point_contents_walk.sv -----
`timescale 1ns / 1ps
// Point classification against a loaded BSP hull. Items pass a two-stage front
// that reduces the node's plane index, then a two-entry queue, then the walker,
// which also performs the node and plane table writes in item order. A load or
// no-op item goes from idle through the done state only. A query visits, for
// every node, a check, the node table read, the dependent plane table read and
// a step; general planes add the MY, MZ and MS states, where the single 32x32
// multiplier is used once per axis. A walk that stops on a bad node or the step
// limit ends with one more check. A walk stops with status 1 at a node outside
// first_node..last_node or at or beyond NODE_COUNT, and with status 2 after
// NODE_COUNT nodes without reaching a leaf.
module bsp_point_contents_walk #(
	parameter int NODE_COUNT  = 1024,
	parameter int PLANE_COUNT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [9:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [9:0]         index,
	input  logic [9:0]         plane_num,
	input  logic signed [10:0] child_front,
	input  logic signed [10:0] child_back,
	input  logic [2:0]         plane_type,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic signed [31:0] plane_offset,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [4:0]  contents,
	output logic [1:0]         status
);
	import bpcw_pkg::*;

	logic [9:0] first_q;
	logic [9:0] last_q;
	bpcw_item_t push_item;
	bpcw_item_t pop_item;
	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 10'd0;
			last_q  <= 10'd1023;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIRST_NODE: first_q <= cfg_wdata;
				REG_LAST_NODE:  last_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	bpcw_front #(.NODE_COUNT(NODE_COUNT), .PLANE_COUNT(PLANE_COUNT)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.index        (index),
		.plane_num    (plane_num),
		.child_front  (child_front),
		.child_back   (child_back),
		.plane_type   (plane_type),
		.vec_x        (vec_x),
		.vec_y        (vec_y),
		.vec_z        (vec_z),
		.plane_offset (plane_offset),
		.q_push       (q_push),
		.q_item       (push_item),
		.q_full       (q_full)
	);

	bpcw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	bpcw_walk #(.NODE_COUNT(NODE_COUNT), .PLANE_COUNT(PLANE_COUNT)) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_item     (pop_item),
		.first_node (first_q),
		.last_node  (last_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.contents   (contents),
		.status     (status)
	);
endmodule

// ----- hdl/bpcw_checker.sv -----
`timescale 1ns / 1ps
`include "bsp_point_contents_walk_assert.svh"
module bpcw_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [4:0] contents,
	input logic [1:0]        status
);
	import bpcw_pkg::*;

	// stalled result holds
	`BPCW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(contents) && $stable(status))
	// only the three defined status codes
	`BPCW_ASSERT_NOW(a_status_code, out_valid, status == STATUS_OK || status == STATUS_BAD_NODE || status == STATUS_LOOP)
	// a failed walk carries no contents
	`BPCW_ASSERT_NOW(a_fail_zero, out_valid && status != STATUS_OK, contents == 5'sd0)
	// ok results are zero or a leaf code
	`BPCW_ASSERT_NOW(a_ok_leaf, out_valid && status == STATUS_OK, contents[4] || contents == 5'sd0)
endmodule

bind bsp_point_contents_walk bpcw_checker u_checker (.*);

// ----- tb/tb_bsp_point_contents_walk.sv -----
`timescale 1ns / 1ps
module tb_bsp_point_contents_walk;
	import bpcw_pkg::*;

	localparam int NODE_COUNT = 1024;
	localparam int PLANE_COUNT = 1024;
	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic signed [4:0] contents;
		logic [1:0]        status;
	} verdict_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = REG_FIRST_NODE;
	logic [9:0]         cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         op = OP_LOAD_NODE;
	logic [9:0]         index = '0;
	logic [9:0]         plane_num = '0;
	logic signed [10:0] child_front = '0;
	logic signed [10:0] child_back = '0;
	logic [2:0]         plane_type = '0;
	logic signed [31:0] vec_x = '0;
	logic signed [31:0] vec_y = '0;
	logic signed [31:0] vec_z = '0;
	logic signed [31:0] plane_offset = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [4:0]  contents;
	logic [1:0]         status;

	bpcw_node_t  node_tab [NODE_COUNT];
	bpcw_plane_t plane_tab [PLANE_COUNT];
	logic [9:0]  lo_node = 10'd0;
	logic [9:0]  hi_node = 10'd1023;

	bpcw_item_t  pending_items [$];
	verdict_t    expected_verdicts [$];
	bpcw_item_t  offered;
	int          plane_pool [$];
	int          items_sent = 0;
	int          mismatches = 0;
	int          cycles = 0;
	int          send_gap = 0;
	int          sink_gap = 0;
	int          stall_left = 0;
	int          hold_request = 0;
	bit          calm = 1'b0;

	bsp_point_contents_walk #(
		.NODE_COUNT(NODE_COUNT),
		.PLANE_COUNT(PLANE_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.index(index),
		.plane_num(plane_num),
		.child_front(child_front),
		.child_back(child_back),
		.plane_type(plane_type),
		.vec_x(vec_x),
		.vec_y(vec_y),
		.vec_z(vec_z),
		.plane_offset(plane_offset),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.contents(contents),
		.status(status)
	);

	always #10 clk = ~clk;

	// sign of the point's distance to a plane, exact
	function automatic bit point_behind(bpcw_plane_t pl, logic signed [31:0] px,
		logic signed [31:0] py, logic signed [31:0] pz);
		longint c;
		longint d;
		longint p1;
		longint p2;
		longint p3;
		logic signed [67:0] acc;
		d = $signed(pl.offs);
		if (pl.kind < AXIAL_KINDS) begin
			case (pl.kind)
				KIND_X: c = px;
				KIND_Y: c = py;
				default: c = pz;
			endcase
			return (c - d) < 0;
		end
		p1 = longint'($signed(pl.nx)) * longint'(px);
		p2 = longint'($signed(pl.ny)) * longint'(py);
		p3 = longint'($signed(pl.nz)) * longint'(pz);
		acc = p1;
		acc = acc + p2;
		acc = acc + p3;
		acc = acc - d * 65536;
		return acc[67];
	endfunction

	function automatic verdict_t classify_point(logic [9:0] start, logic signed [31:0] px,
		logic signed [31:0] py, logic signed [31:0] pz);
		verdict_t v;
		int num;
		int steps;
		bpcw_node_t nd;
		logic signed [10:0] nxt;
		v.contents = '0;
		v.status = STATUS_LOOP;
		num = int'(start);
		for (steps = 0; steps < NODE_COUNT; steps++) begin
			if (num < int'(lo_node) || num > int'(hi_node) || num >= NODE_COUNT) begin
				v.status = STATUS_BAD_NODE;
				break;
			end
			nd = node_tab[num];
			nxt = point_behind(plane_tab[nd.plane_idx], px, py, pz) ? nd.back : nd.front;
			num = int'(nxt);
			if (num < 0) begin
				v.contents = 5'((num < -16) ? -16 : num);
				v.status = STATUS_OK;
				break;
			end
		end
		return v;
	endfunction

	function automatic void absorb_item(bpcw_item_t it);
		verdict_t v;
		v.contents = '0;
		v.status = STATUS_OK;
		case (it.cls)
			OP_LOAD_NODE: begin
				node_tab[it.index].plane_idx = it.plane_num;
				node_tab[it.index].front = it.child_front;
				node_tab[it.index].back = it.child_back;
			end
			OP_LOAD_PLANE: begin
				plane_tab[it.index].kind = it.kind;
				plane_tab[it.index].nx = it.vx;
				plane_tab[it.index].ny = it.vy;
				plane_tab[it.index].nz = it.vz;
				plane_tab[it.index].offs = it.offs;
			end
			OP_QUERY: v = classify_point(it.index, it.vx, it.vy, it.vz);
			default: ;
		endcase
		expected_verdicts.push_back(v);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// sender: one transaction offered at a time, occasional idle bursts between them
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				absorb_item(offered);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					offered = pending_items.pop_front();
					op <= offered.cls;
					index <= offered.index;
					plane_num <= offered.plane_num;
					child_front <= offered.child_front;
					child_back <= offered.child_back;
					plane_type <= offered.kind;
					vec_x <= offered.vx;
					vec_y <= offered.vy;
					vec_z <= offered.vz;
					plane_offset <= offered.offs;
					in_valid <= 1'b1;
					if (!calm && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 7);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: compares each transaction with the oldest expectation
	always @(posedge clk) begin
		verdict_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch("result with nothing pending", contents, 0);
				end else begin
					want = expected_verdicts.pop_front();
					if (contents !== want.contents)
						report_mismatch("contents", contents, want.contents);
					if (status !== want.status)
						report_mismatch("status", status, want.status);
				end
			end
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0)
					sink_gap = $urandom_range(1, 7);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic bpcw_item_t junk_item(logic [1:0] code);
		bpcw_item_t it;
		it.cls = code;
		it.index = 10'($urandom);
		it.plane_num = 10'($urandom);
		it.child_front = 11'($urandom);
		it.child_back = 11'($urandom);
		it.kind = 3'($urandom);
		it.vx = $urandom;
		it.vy = $urandom;
		it.vz = $urandom;
		it.offs = $urandom;
		return it;
	endfunction

	function automatic void queue_item(bpcw_item_t it);
		pending_items.push_back(it);
		if (it.cls != OP_RESERVED)
			items_sent++;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		int tmp;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: begin
				tmp = $urandom_range(0, 393216);
				return tmp - 196608;
			end
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h80000000;
					1: return 32'h7fffffff;
					2: return 32'h00000000;
					default: return 32'hffffffff;
				endcase
			end
			default: begin
				tmp = $urandom_range(0, 65535);
				return (tmp - 32768) <<< 16;
			end
		endcase
	endfunction

	function automatic logic signed [31:0] rand_normal();
		int tmp;
		if ($urandom_range(0, 1) == 0)
			return rand_coord();
		tmp = $urandom_range(0, 131072);
		return tmp - 65536;
	endfunction

	function automatic void load_plane(int idx, int kind, logic signed [31:0] nx,
		logic signed [31:0] ny, logic signed [31:0] nz, logic signed [31:0] offs);
		bpcw_item_t it;
		it = junk_item(OP_LOAD_PLANE);
		it.index = 10'(idx);
		it.kind = 3'(kind);
		it.vx = nx;
		it.vy = ny;
		it.vz = nz;
		it.offs = offs;
		queue_item(it);
		plane_pool.push_back(idx);
	endfunction

	function automatic void load_node(int idx, int pn, int front, int back);
		bpcw_item_t it;
		it = junk_item(OP_LOAD_NODE);
		it.index = 10'(idx);
		it.plane_num = 10'(pn);
		it.child_front = 11'(front);
		it.child_back = 11'(back);
		queue_item(it);
	endfunction

	function automatic void ask(int start, logic signed [31:0] x, logic signed [31:0] y,
		logic signed [31:0] z);
		bpcw_item_t it;
		it = junk_item(OP_QUERY);
		it.index = 10'(start);
		it.vx = x;
		it.vy = y;
		it.vz = z;
		queue_item(it);
	endfunction

	function automatic int pooled_plane();
		return plane_pool[$urandom_range(0, plane_pool.size() - 1)];
	endfunction

	// node index outside the configured range, or -1 if there is none
	function automatic int outside_node();
		if (lo_node > hi_node)
			return $urandom_range(0, 1023);
		if (lo_node > 0 && (hi_node == 10'd1023 || $urandom_range(0, 1) == 0))
			return $urandom_range(0, int'(lo_node) - 1);
		if (hi_node < 10'd1023)
			return $urandom_range(int'(hi_node) + 1, 1023);
		return -1;
	endfunction

	function automatic int pick_child(int lowest, int highest);
		int bad;
		case ($urandom_range(0, 7))
			4, 5: if (lowest <= highest) return $urandom_range(lowest, highest);
			6: begin
				bad = outside_node();
				if (bad >= 0) return bad;
			end
			7: return ($urandom_range(0, 1) == 0) ? -16 : -1;
			default: ;
		endcase
		return -int'($urandom_range(1, 16));
	endfunction

	// a fresh subtree on a contiguous node range; children in the range lie only at higher indices
	function automatic void build_and_probe();
		int k;
		int span;
		int base;
		int n;
		repeat ($urandom_range(1, 3))
			load_plane($urandom_range(0, 1023), $urandom_range(0, 7), rand_normal(),
				rand_normal(), rand_normal(), rand_coord());
		span = int'(hi_node) - int'(lo_node) + 1;
		k = $urandom_range(1, 12);
		if (k > span)
			k = span;
		base = $urandom_range(int'(lo_node), int'(hi_node) - k + 1);
		for (n = base + k - 1; n >= base; n--)
			load_node(n, pooled_plane(), pick_child(n + 1, base + k - 1),
				pick_child(n + 1, base + k - 1));
		repeat ($urandom_range(4, 12))
			ask(base + $urandom_range(0, k - 1), rand_coord(), rand_coord(), rand_coord());
	endfunction

	// one or two nodes pointing at each other, then a walk into them
	function automatic void loop_probe();
		int n;
		int m;
		n = $urandom_range(int'(lo_node), int'(hi_node));
		m = (n < int'(hi_node)) ? n + 1 : n;
		load_node(n, pooled_plane(), m, m);
		load_node(m, pooled_plane(), n, n);
		ask(n, rand_coord(), rand_coord(), rand_coord());
	endfunction

	function automatic void noise();
		int bad;
		case ($urandom_range(0, 3))
			0: queue_item(junk_item(OP_RESERVED));
			1: load_plane($urandom_range(0, 1023), $urandom_range(0, 7), rand_normal(),
				rand_normal(), rand_normal(), rand_coord());
			2: begin
				bad = outside_node();
				if (bad >= 0)
					ask(bad, rand_coord(), rand_coord(), rand_coord());
				else
					queue_item(junk_item(OP_RESERVED));
			end
			default: load_node($urandom_range(0, 1023), pooled_plane(),
				int'($urandom_range(0, 1039)) - 16, int'($urandom_range(0, 1039)) - 16);
		endcase
	endfunction

	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_cfg(logic which, logic [9:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (which == REG_FIRST_NODE)
			lo_node = val;
		else
			hi_node = val;
	endtask

	task automatic run_phase(logic [9:0] first, logic [9:0] last, int budget, bit long_hold);
		int goal;
		int loops;
		int pick;
		write_cfg(REG_FIRST_NODE, first);
		write_cfg(REG_LAST_NODE, last);
		@(negedge clk);
		goal = items_sent + budget;
		loops = 0;
		while (items_sent < goal) begin
			pick = $urandom_range(0, 9);
			if (first <= last && pick < 7) begin
				build_and_probe();
			end else if (first <= last && pick == 7 && loops < 2) begin
				loop_probe();
				loops++;
			end else begin
				noise();
			end
		end
		if (long_hold)
			hold_request = 400;
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// axial planes, general planes and extreme normals
		load_plane(0, KIND_X, 0, 0, 0, 0);
		load_plane(1023, KIND_Y, 0, 0, 0, 32'h00010000);
		load_plane(2, 2, 0, 0, 0, -32'sh00010000);
		load_plane(3, 7, 32'h00010000, 0, 0, 0);
		load_plane(4, 3, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
		load_plane(5, 5, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
		load_node(1023, 0, -1, -16);
		load_node(1022, 1023, 1023, -2);
		load_node(1021, 2, -3, 1022);
		load_node(10, 3, 1021, -17);
		load_node(11, 4, -4, -5);
		load_node(12, 5, -6, -7);
		load_node(13, 3, 13, 13);
		ask(1023, 0, 0, 0);
		ask(1023, -1, 0, 0);
		ask(1023, 32'h80000000, 0, 0);
		ask(1023, 32'h7fffffff, 0, 0);
		ask(10, -1, 0, 0);
		ask(10, 32'h00050000, 32'h00010000, -32'sh00010000);
		ask(10, 32'h00010000, 32'h00010000, -32'sh00020000);
		ask(11, 32'h80000000, 32'h80000000, 32'h80000000);
		ask(11, 32'h7fffffff, 32'h80000000, 32'h80000000);
		ask(12, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		ask(13, 0, 0, 0);
		queue_item(junk_item(OP_RESERVED));
		wait_drained();

		run_phase(10'd0, 10'd1023, 300, 1'b1);
		run_phase(10'd100, 10'd900, 200, 1'b0);
		run_phase(10'd1000, 10'd1023, 150, 1'b0);
		run_phase(10'd0, 10'd0, 120, 1'b0);
		run_phase(10'd1023, 10'd1023, 100, 1'b0);
		run_phase(10'd700, 10'd300, 120, 1'b0);
		calm = 1'b1;
		run_phase(10'd0, 10'd1023, 450, 1'b0);

		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_verdicts.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
